FILE: rtl/core/cidt_pkg.sv
// Shared types and constants for the card ID table.
package cidt_pkg;

	// Defaults for the top-level parameters.
	localparam int ROOMS_DEF          = 16;
	localparam int SLOTS_PER_ROOM_DEF = 4;
	localparam int ID_BYTES_DEF       = 4;

	// Width of room numbers carried along the chain; covers up to 127 rooms plus "none".
	localparam int RoomFw = 7;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_MATCH  = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_CLEARED   = 3'd5,
		ST_BAD       = 3'd6
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_RUN
	} fsm_t;

	// Operation token that walks the row of room cells.
	typedef struct packed {
		logic              valid;
		mode_t             mode;
		logic              done;
		status_t           status;
		logic [RoomFw-1:0] tgt;
		logic [RoomFw-1:0] found;
	} tok_t;

endpackage

FILE: rtl/core/cidt_cell.sv
// One room of the card table: its slots, the compare logic and one token stage.
module cidt_cell #(
	parameter int ROOM_IDX       = 0,
	parameter int SLOTS_PER_ROOM = cidt_pkg::SLOTS_PER_ROOM_DEF,
	parameter int ID_W           = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cidt_pkg::tok_t     tok_i,
	input  logic [ID_W-1:0]    id,
	output cidt_pkg::tok_t     tok_o
);
	import cidt_pkg::*;

	localparam int SlotW = (SLOTS_PER_ROOM > 1) ? $clog2(SLOTS_PER_ROOM) : 1;

	logic [ID_W-1:0]           slot_q [SLOTS_PER_ROOM];
	logic [SLOTS_PER_ROOM-1:0] hit;
	logic [SLOTS_PER_ROOM-1:0] empty;
	logic [SlotW-1:0]          first_empty;
	logic                      any_hit;
	logic                      has_empty;
	logic                      active;
	logic                      mine;
	tok_t                      tok_n;
	tok_t                      tok_q;

	always_comb begin
		for (int s = 0; s < SLOTS_PER_ROOM; s++) begin
			hit[s]   = (slot_q[s] == id);
			empty[s] = (slot_q[s] == '0);
		end
		// Scan downward so that the lowest empty slot wins.
		first_empty = '0;
		for (int s = SLOTS_PER_ROOM - 1; s >= 0; s--) begin
			if (empty[s]) begin
				first_empty = SlotW'(s);
			end
		end
	end

	assign any_hit   = |hit;
	assign has_empty = |empty;
	assign active    = tok_i.valid && !tok_i.done;
	assign mine      = active && (tok_i.tgt == RoomFw'(ROOM_IDX));

	always_comb begin
		tok_n = tok_i;
		if (active) begin
			unique case (tok_i.mode)
				MODE_INSERT: begin
					if (mine) begin
						tok_n.done = 1'b1;
						if (any_hit) begin
							tok_n.status = ST_DUPLICATE;
						end else if (has_empty) begin
							tok_n.status = ST_STORED;
						end else begin
							tok_n.status = ST_REPLACED;
						end
					end
				end
				MODE_MATCH: begin
					if (any_hit) begin
						tok_n.done   = 1'b1;
						tok_n.status = ST_FOUND;
						tok_n.found  = RoomFw'(ROOM_IDX);
					end
				end
				MODE_CLEAR: begin
					if (mine) begin
						tok_n.done   = 1'b1;
						tok_n.status = ST_CLEARED;
					end
				end
				default: begin
					tok_n = tok_i;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			for (int s = 0; s < SLOTS_PER_ROOM; s++) begin
				slot_q[s] <= '0;
			end
		end else begin
			tok_q <= tok_n;
			if (mine && (tok_i.mode == MODE_INSERT) && !any_hit) begin
				if (has_empty) begin
					slot_q[first_empty] <= id;
				end else begin
					// Full room: drop the oldest slot and append at the end.
					for (int s = 0; s < SLOTS_PER_ROOM - 1; s++) begin
						slot_q[s] <= slot_q[s+1];
					end
					slot_q[SLOTS_PER_ROOM-1] <= id;
				end
			end else if (mine && (tok_i.mode == MODE_CLEAR)) begin
				for (int s = 0; s < SLOTS_PER_ROOM; s++) begin
					slot_q[s] <= '0;
				end
			end
		end
	end

	assign tok_o = tok_q;

endmodule

FILE: rtl/core/card_id_table_fifo_unit.sv
// Top level of the card ID table: command port, token launch and result register.
// A command is taken when start is high and busy is low. Its token then walks
// a row of ROOMS room cells, each of which registers it, and the result appears
// on status and found_room with done high for exactly one cycle; the length of
// the cell row sets when it appears, and every operation takes the same time.
// busy stays high from the accepting edge until the result is registered, so a
// new command can be taken in the cycle in which done is shown, and only one
// command is in the row at a time. The receiver cannot stall: a result must be
// taken in the cycle in which done is high.
// Every slot is empty after reset.
module card_id_table_fifo_unit #(
	parameter int ROOMS          = cidt_pkg::ROOMS_DEF,
	parameter int SLOTS_PER_ROOM = cidt_pkg::SLOTS_PER_ROOM_DEF,
	parameter int ID_BYTES       = cidt_pkg::ID_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [3:0]  room,
	input  logic [31:0] card_id,
	output logic        done,
	output logic [2:0]  status,
	output logic [4:0]  found_room
);
	import cidt_pkg::*;

	localparam int IdW = (ID_BYTES >= 4) ? 32 : ID_BYTES * 8;

	fsm_t             state_q;
	fsm_t             state_n;
	logic             accept;
	logic             room_ok;
	mode_t            mode_in;
	tok_t             tok_launch;
	tok_t             tok_s0;
	tok_t             chain [ROOMS+1];
	tok_t             last;
	logic [IdW-1:0]   id_q;
	logic             done_q;
	status_t          status_q;
	logic [RoomFw-1:0] found_q;

	assign busy    = (state_q != FSM_IDLE);
	assign accept  = start && !busy;
	assign mode_in = mode_t'(mode);
	assign room_ok = ({3'b000, room} < RoomFw'(ROOMS));

	// Requests that no cell can serve are finished before launch.
	always_comb begin
		tok_launch        = '0;
		tok_launch.valid  = 1'b1;
		tok_launch.mode   = mode_in;
		tok_launch.status = ST_BAD;
		tok_launch.tgt    = room_ok ? RoomFw'(room) : '0;
		tok_launch.found  = RoomFw'(ROOMS);
		unique case (mode_in)
			MODE_INSERT, MODE_CLEAR: tok_launch.done = !room_ok;
			MODE_MATCH:              tok_launch.done = 1'b0;
			default:                 tok_launch.done = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
		end else if (accept) begin
			tok_s0 <= tok_launch;
		end else begin
			tok_s0 <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= card_id[IdW-1:0];
		end
	end

	assign chain[0] = tok_s0;

	for (genvar r = 0; r < ROOMS; r++) begin : g_room
		cidt_cell #(
			.ROOM_IDX       (r),
			.SLOTS_PER_ROOM (SLOTS_PER_ROOM),
			.ID_W           (IdW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (chain[r]),
			.id     (id_q),
			.tok_o  (chain[r+1])
		);
	end

	assign last = chain[ROOMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_n = FSM_RUN;
				end
			end
			FSM_RUN: begin
				if (last.valid) begin
					state_n = FSM_IDLE;
				end
			end
			default: begin
				state_n = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	// A token that leaves the row unfinished is a match that found no room.
	always_ff @(posedge clk) begin
		if (last.valid) begin
			status_q <= last.done ? last.status : ST_NOT_FOUND;
			found_q  <= last.found;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign found_room = 5'(found_q);

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the card ID table: queued commands, table predictor, result check.
`timescale 1ns / 100ps

module testbench;
	import cidt_pkg::*;

	localparam int N_ROOMS     = ROOMS_DEF;
	localparam int N_SLOTS     = SLOTS_PER_ROOM_DEF;
	localparam int N_ID_BYTES  = ID_BYTES_DEF;
	localparam logic [31:0] ID_MASK = (N_ID_BYTES >= 4) ? 32'hFFFF_FFFF :
		((32'h1 << (8 * N_ID_BYTES)) - 32'h1);
	localparam int RANDOM_CMDS = 1800;
	localparam int CYCLE_LIMIT = 400000;
	// The one mode encoding that the block does not serve.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  room;
		logic [31:0] id;
		bit          drain;
	} tap_cmd_t;

	typedef struct {
		status_t    status;
		logic [4:0] room;
	} tap_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = 2'd0;
	logic [3:0]  room = 4'd0;
	logic [31:0] card_id = 32'd0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [4:0]  found_room;

	tap_cmd_t     cmd_queue[$];
	tap_outcome_t outcome_queue[$];
	logic [31:0]  card_table [N_ROOMS * N_SLOTS];
	int           err_count = 0;
	int           sent_cnt = 0;
	int           cycle_cnt = 0;
	int           status_seen [0:7];

	tap_cmd_t     next_cmd;
	tap_outcome_t got_outcome;
	status_t      pred_status;
	logic [4:0]   pred_room;

	card_id_table_fifo_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.room       (room),
		.card_id    (card_id),
		.done       (done),
		.status     (status),
		.found_room (found_room)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit room_holds(input int r, input logic [31:0] id);
		bit hit;
		hit = 1'b0;
		for (int s = 0; s < N_SLOTS; s++)
			if (card_table[r * N_SLOTS + s] == id)
				hit = 1'b1;
		return hit;
	endfunction

	// Applies one transaction to the shadow table and yields the result it should produce.
	task automatic table_apply(input logic [1:0] op, input logic [3:0] rm,
			input logic [31:0] raw_id, output status_t st, output logic [4:0] fr);
		int          base;
		bit          placed;
		bit          hit;
		logic [31:0] id;
		id     = raw_id & ID_MASK;
		base   = int'(rm) * N_SLOTS;
		placed = 1'b0;
		hit    = 1'b0;
		st     = ST_BAD;
		fr     = 5'(N_ROOMS);
		case (op)
			MODE_INSERT: begin
				if (int'(rm) < N_ROOMS) begin
					if (room_holds(int'(rm), id)) begin
						st = ST_DUPLICATE;
					end else begin
						for (int s = 0; s < N_SLOTS; s++)
							if (!placed && card_table[base + s] == 32'd0) begin
								card_table[base + s] = id;
								placed = 1'b1;
							end
						if (placed) begin
							st = ST_STORED;
						end else begin
							// Full room: the oldest entry drops out and the new ID goes last.
							for (int s = 0; s + 1 < N_SLOTS; s++)
								card_table[base + s] = card_table[base + s + 1];
							card_table[base + N_SLOTS - 1] = id;
							st = ST_REPLACED;
						end
					end
				end
			end
			MODE_MATCH: begin
				st = ST_NOT_FOUND;
				for (int r = 0; r < N_ROOMS; r++)
					if (!hit && room_holds(r, id)) begin
						hit = 1'b1;
						fr  = 5'(r);
						st  = ST_FOUND;
					end
			end
			MODE_CLEAR: begin
				if (int'(rm) < N_ROOMS) begin
					for (int s = 0; s < N_SLOTS; s++)
						card_table[base + s] = 32'd0;
					st = ST_CLEARED;
				end
			end
			default: st = ST_BAD;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
		err_count++;
	endtask

	task automatic add_cmd(input logic [1:0] op, input logic [3:0] rm, input logic [31:0] id,
			input bit drain);
		tap_cmd_t c;
		c.op    = op;
		c.room  = rm;
		c.id    = id;
		c.drain = drain;
		cmd_queue.push_back(c);
	endtask

	// Driver: a transaction is taken at an edge where start is high and busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				table_apply(mode, room, card_id, pred_status, pred_room);
				outcome_queue.push_back('{pred_status, pred_room});
				sent_cnt++;
			end
			if (!start || !busy) begin
				if (cmd_queue.size() == 0 ||
						(cmd_queue[0].drain && outcome_queue.size() != 0) ||
						(!(sent_cnt >= 800 && sent_cnt < 1100) &&
						$urandom_range(0, 99) < 25)) begin
					start <= 1'b0;
				end else begin
					next_cmd = cmd_queue.pop_front();
					start   <= 1'b1;
					mode    <= next_cmd.op;
					room    <= next_cmd.room;
					card_id <= next_cmd.id;
				end
			end
		end
	end

	// Monitor: done marks a result that must be taken in that very cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			status_seen[status]++;
			if (outcome_queue.size() == 0) begin
				report_mismatch("result with no transaction pending", 0, status);
			end else begin
				got_outcome = outcome_queue.pop_front();
				if (status !== got_outcome.status)
					report_mismatch("status", got_outcome.status, status);
				if (found_room !== got_outcome.room)
					report_mismatch("found_room", got_outcome.room, found_room);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout with %0d results outstanding", outcome_queue.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [31:0] id_pool [16];
		logic [1:0]  op;
		logic [3:0]  rm;
		logic [31:0] id;
		int          pick;
		for (int i = 0; i < N_ROOMS * N_SLOTS; i++)
			card_table[i] = 32'd0;
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		for (int i = 0; i < 16; i++)
			id_pool[i] = $urandom;

		// Directed part: zero IDs, extreme IDs, full-room shift, clears and the unused mode.
		add_cmd(MODE_MATCH, 4'd0, 32'd0, 1'b0);
		add_cmd(MODE_INSERT, 4'd0, 32'd0, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'hFFFF_FFFF, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'hFFFF_FFFF, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'h0000_0001, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'h0000_0002, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'h8000_0000, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'h0000_0003, 1'b0);
		add_cmd(MODE_INSERT, 4'd15, 32'd0, 1'b0);
		add_cmd(MODE_MATCH, 4'd7, 32'hFFFF_FFFF, 1'b0);
		add_cmd(MODE_MATCH, 4'd0, 32'h0000_0003, 1'b0);
		add_cmd(MODE_INSERT, 4'd0, 32'h5A5A_5A5A, 1'b0);
		add_cmd(MODE_INSERT, 4'd0, 32'hA5A5_A5A5, 1'b0);
		add_cmd(MODE_INSERT, 4'd0, 32'h0000_0003, 1'b0);
		add_cmd(MODE_INSERT, 4'd0, 32'h1234_5678, 1'b0);
		add_cmd(MODE_MATCH, 4'd0, 32'd0, 1'b0);
		add_cmd(MODE_MATCH, 4'd3, 32'h0000_0003, 1'b0);
		add_cmd(MODE_SPARE, 4'd15, 32'hFFFF_FFFF, 1'b0);
		add_cmd(MODE_SPARE, 4'd0, 32'd0, 1'b0);
		add_cmd(MODE_CLEAR, 4'd15, 32'h0000_0003, 1'b1);
		add_cmd(MODE_CLEAR, 4'd15, 32'd0, 1'b0);
		add_cmd(MODE_MATCH, 4'd0, 32'h0000_0001, 1'b0);
		add_cmd(MODE_CLEAR, 4'd0, 32'd0, 1'b0);
		add_cmd(MODE_MATCH, 4'd9, 32'h0000_0003, 1'b0);
		add_cmd(MODE_MATCH, 4'd0, 32'd0, 1'b0);

		// Random part: a few hot rooms and a small ID pool so that rooms fill,
		// overflow and produce duplicates and hits; the rest is full-range noise.
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = MODE_INSERT;
			else if (pick < 80)
				op = MODE_MATCH;
			else if (pick < 93)
				op = MODE_CLEAR;
			else
				op = MODE_SPARE;
			if ($urandom_range(0, 99) < 75)
				rm = 4'($urandom_range(0, 3));
			else
				rm = 4'($urandom_range(0, 15));
			pick = $urandom_range(0, 99);
			if (pick < 8)
				id = 32'd0;
			else if (pick < 80)
				id = id_pool[$urandom_range(0, 15)];
			else
				id = $urandom;
			add_cmd(op, rm, id, n == 400 || n == 1300);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || start)
			@(posedge clk);
		while (outcome_queue.size() != 0)
			@(posedge clk);
		repeat (N_ROOMS + 8) @(posedge clk);
		if (outcome_queue.size() != 0)
			report_mismatch("results never delivered", 0, outcome_queue.size());

		$display("Sent %0d transactions in %0d cycles: stored %0d, replaced %0d, duplicate %0d,",
			sent_cnt, cycle_cnt, status_seen[ST_STORED], status_seen[ST_REPLACED],
			status_seen[ST_DUPLICATE]);
		$display("found %0d, not found %0d, cleared %0d, bad request %0d; %0d mismatches.",
			status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_CLEARED],
			status_seen[ST_BAD], err_count);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
